// ----- rtl/srisc_pkg.sv -----
// Shared types and constants for the small RISC step block.
`timescale 1ns / 1ps
package srisc_pkg;
    localparam int MEM_WORDS = 65536;
    localparam int AW = $clog2(MEM_WORDS);

    localparam logic [1:0] REQ_WR = 2'd0;
    localparam logic [1:0] REQ_EX = 2'd1;
    localparam logic [1:0] REQ_RD = 2'd2;

    localparam logic [4:0] OP_ADD = 5'd0;
    localparam logic [4:0] OP_SUB = 5'd1;
    localparam logic [4:0] OP_LSF = 5'd2;
    localparam logic [4:0] OP_RSF = 5'd3;
    localparam logic [4:0] OP_AND = 5'd4;
    localparam logic [4:0] OP_OR  = 5'd5;
    localparam logic [4:0] OP_XOR = 5'd6;
    localparam logic [4:0] OP_LHI = 5'd7;
    localparam logic [4:0] OP_LD  = 5'd8;
    localparam logic [4:0] OP_ST  = 5'd9;
    localparam logic [4:0] OP_JLT = 5'd16;
    localparam logic [4:0] OP_JLE = 5'd17;
    localparam logic [4:0] OP_JEQ = 5'd18;
    localparam logic [4:0] OP_JNE = 5'd19;
    localparam logic [4:0] OP_JIN = 5'd20;
    localparam logic [4:0] OP_HLT = 5'd24;

    typedef struct packed {
        logic [1:0]  req;
        logic [15:0] addr;
        logic [31:0] wdata;
    } t_req;

    typedef struct packed {
        logic [31:0] rdata;
        logic [15:0] pc;
        logic        halted;
        logic        bad;
        logic        dropped;
        logic [31:0] count;
    } t_res;
endpackage

// ----- rtl/srisc_front.sv -----
// Front end: accepts request words and queues them for the execute unit.
`timescale 1ns / 1ps
module srisc_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  srisc_pkg::t_req   i_req,
    output logic              o_valid,
    input  logic              i_ready,
    output srisc_pkg::t_req   o_req
);
    import srisc_pkg::*;
    t_req       r_q [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;
    logic       push, pop;

    assign o_ready = (r_cnt != 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_req   = r_q[r_rp];
    assign push    = i_valid && o_ready;
    assign pop     = o_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wp] <= i_req;
        end
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) r_wp <= ~r_wp;
            if (pop) r_rp <= ~r_rp;
            r_cnt <= r_cnt + {1'b0, push} - {1'b0, pop};
        end
    end
endmodule

// ----- rtl/srisc_back.sv -----
// Back end: memory clear, memory access and instruction execution.
`timescale 1ns / 1ps
module srisc_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  srisc_pkg::t_req   i_req,
    output logic              o_valid,
    input  logic              i_ready,
    output srisc_pkg::t_res   o_res
);
    import srisc_pkg::*;
    localparam logic [2:0] S_CLR = 3'd0;
    localparam logic [2:0] S_IDLE = 3'd1;
    localparam logic [2:0] S_FETCH = 3'd2;
    localparam logic [2:0] S_EXEC = 3'd3;
    localparam logic [2:0] S_LOAD = 3'd4;
    localparam logic [2:0] S_RDOUT = 3'd5;

    logic [31:0] r_mem [MEM_WORDS];
    logic [31:0] r_rdata;
    logic [31:0] r_rf [8];
    logic [2:0]  r_st;
    logic [AW:0] r_clr;
    logic [15:0] r_pc;
    logic        r_halt;
    logic [31:0] r_cnt;
    logic [31:0] r_inst;
    logic        r_ovalid;
    logic        n_ovalid;
    t_res        r_res;

    logic        me_we, me_re;
    logic [AW-1:0] me_waddr, me_raddr;
    logic [31:0] me_wdata;

    logic [4:0]  op;
    logic [2:0]  dst, s0, s1;
    logic [15:0] imm;
    logic [31:0] sx, v0, v1, vd, alu;
    logic        wr, jmp, bad, outfree;
    logic [15:0] tgt;

    assign outfree = !r_ovalid || i_ready;
    assign o_valid = r_ovalid;
    assign o_res   = r_res;
    assign o_ready = (r_st == S_IDLE) && outfree;

    assign op  = r_inst[29:25];
    assign dst = r_inst[24:22];
    assign s0  = r_inst[21:19];
    assign s1  = r_inst[18:16];
    assign imm = r_inst[15:0];
    assign sx  = {{16{imm[15]}}, imm};
    assign v0  = (s0 == 3'd0) ? 32'd0 : (s0 == 3'd1) ? sx : r_rf[s0];
    assign v1  = (s1 == 3'd0) ? 32'd0 : (s1 == 3'd1) ? sx : r_rf[s1];
    assign vd  = (dst == 3'd0) ? 32'd0 : (dst == 3'd1) ? sx : r_rf[dst];

    always_comb begin
        alu = 32'd0;
        wr  = 1'b0;
        jmp = 1'b0;
        bad = 1'b0;
        tgt = imm;
        case (op)
            OP_ADD: begin alu = v0 + v1; wr = 1'b1; end
            OP_SUB: begin alu = v0 - v1; wr = 1'b1; end
            OP_LSF: begin alu = v0 << v1[4:0]; wr = 1'b1; end
            OP_RSF: begin alu = $unsigned($signed(v0) >>> v1[4:0]); wr = 1'b1; end
            OP_AND: begin alu = v0 & v1; wr = 1'b1; end
            OP_OR:  begin alu = v0 | v1; wr = 1'b1; end
            OP_XOR: begin alu = v0 ^ v1; wr = 1'b1; end
            OP_LHI: begin alu = {imm, vd[15:0]}; wr = 1'b1; end
            OP_LD:  begin wr = 1'b1; end
            OP_ST:  begin end
            OP_JLT: begin jmp = v0 < v1; end
            OP_JLE: begin jmp = v0 <= v1; end
            OP_JEQ: begin jmp = v0 == v1; end
            OP_JNE: begin jmp = v0 != v1; end
            OP_JIN: begin jmp = 1'b1; tgt = v0[15:0]; end
            OP_HLT: begin end
            default: begin bad = 1'b1; end
        endcase
    end

    // single memory port pair: one write, one registered read
    always_comb begin
        me_we    = 1'b0;
        me_re    = 1'b0;
        me_waddr = r_clr[AW-1:0];
        me_wdata = 32'd0;
        me_raddr = i_req.addr[AW-1:0];
        case (r_st)
            S_CLR: me_we = 1'b1;
            S_IDLE: begin
                if (i_valid && outfree) begin
                    if (i_req.req == REQ_WR) begin
                        me_we    = 1'b1;
                        me_waddr = i_req.addr[AW-1:0];
                        me_wdata = i_req.wdata;
                    end else if (i_req.req == REQ_RD) begin
                        me_re = 1'b1;
                    end else if (i_req.req == REQ_EX && !r_halt) begin
                        me_re    = 1'b1;
                        me_raddr = r_pc[AW-1:0];
                    end
                end
            end
            S_EXEC: begin
                me_raddr = v1[AW-1:0];
                me_re    = (op == OP_LD);
                me_we    = (op == OP_ST);
                me_waddr = v1[AW-1:0];
                me_wdata = v0;
            end
            default: begin end
        endcase
    end

    // output word valid: held until taken, set when a word completes
    always_comb begin
        n_ovalid = r_ovalid && !i_ready;
        case (r_st)
            S_IDLE: begin
                if (i_valid && outfree && (i_req.req != REQ_RD)
                        && !(i_req.req == REQ_EX && !r_halt)) begin
                    n_ovalid = 1'b1;
                end
            end
            S_RDOUT, S_LOAD: n_ovalid = 1'b1;
            S_EXEC: begin
                if (op != OP_LD) n_ovalid = 1'b1;
            end
            default: begin end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (me_we) r_mem[me_waddr] <= me_wdata;
        if (me_re) r_rdata <= r_mem[me_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st     <= S_CLR;
            r_clr    <= '0;
            r_pc     <= 16'd0;
            r_halt   <= 1'b0;
            r_cnt    <= 32'd0;
            r_ovalid <= 1'b0;
            for (int k = 0; k < 8; k++) r_rf[k] <= 32'd0;
        end else begin
            r_ovalid <= n_ovalid;
            case (r_st)
                S_CLR: begin
                    r_clr <= r_clr + 1'b1;
                    if (r_clr == (AW + 1)'(MEM_WORDS - 1)) r_st <= S_IDLE;
                end
                S_IDLE: begin
                    if (i_valid && outfree) begin
                        r_res.rdata   <= 32'd0;
                        r_res.pc      <= r_pc;
                        r_res.halted  <= r_halt;
                        r_res.bad     <= 1'b0;
                        r_res.dropped <= 1'b0;
                        r_res.count   <= r_cnt;
                        if (i_req.req == REQ_RD) begin
                            r_st <= S_RDOUT;
                        end else if (i_req.req == REQ_EX && !r_halt) begin
                            r_st <= S_FETCH;
                        end
                    end
                end
                S_RDOUT: begin
                    r_res.rdata <= r_rdata;
                    r_st        <= S_IDLE;
                end
                S_FETCH: begin
                    r_inst <= r_rdata;
                    r_st   <= S_EXEC;
                end
                S_EXEC: begin
                    r_res.rdata   <= r_inst;
                    r_res.bad     <= bad;
                    r_res.dropped <= wr && (dst == 3'd1);
                    r_res.count   <= r_cnt + 32'd1;
                    r_cnt         <= r_cnt + 32'd1;
                    if (op == OP_HLT) begin
                        r_halt       <= 1'b1;
                        r_res.halted <= 1'b1;
                        r_res.pc     <= r_pc;
                    end else begin
                        r_res.pc <= jmp ? 16'(tgt[AW-1:0]) : 16'((r_pc + 16'd1) & 16'(MEM_WORDS - 1));
                        r_pc     <= jmp ? 16'(tgt[AW-1:0]) : 16'((r_pc + 16'd1) & 16'(MEM_WORDS - 1));
                    end
                    if (jmp) r_rf[7] <= {16'd0, r_pc};
                    if (op == OP_LD) begin
                        r_st <= S_LOAD;
                    end else begin
                        if (wr && dst > 3'd1 && !(jmp && dst == 3'd7)) r_rf[dst] <= alu;
                        r_st     <= S_IDLE;
                    end
                end
                S_LOAD: begin
                    if (dst > 3'd1) r_rf[dst] <= r_rdata;
                    r_st     <= S_IDLE;
                end
                default: r_st <= S_IDLE;
            endcase
        end
    end
endmodule

// ----- rtl/small_risc_instruction_step_top.sv -----
// Top level of the small RISC instruction step block.
//  channel | dir | tdata (low bit up)                  | tuser
//  s_axis  | in  | mem_addr[15:0], mem_wdata[47:16]    | req_type[1:0]
//  m_axis  | out | mem_rdata[31:0], next_pc[47:32],    | -
//          |     | halted, bad_opcode, write_dropped,  |
//          |     | retired_count[82:51], zeros to 87   |
// Back end per word: write stays in IDLE; read via RDOUT; step via FETCH, EXEC; LD also LOAD.
// After reset a clear pass in S_CLR zeroes memory; the queue takes two words meanwhile.
// A two-entry queue decouples input from execution; each word is registered in it first.
// Output is a held register; a stalled output holds the back end in idle.
`timescale 1ns / 1ps
module small_risc_instruction_step_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [47:0] s_axis_tdata,   // mem_addr, mem_wdata
    input  logic [1:0]  s_axis_tuser,   // req_type
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [87:0] m_axis_tdata    // rdata, pc, halted, bad, dropped, count
);
    import srisc_pkg::*;
    t_req in_req, q_req;
    t_res res;
    logic q_valid, q_ready;

    assign in_req.req   = s_axis_tuser;
    assign in_req.addr  = s_axis_tdata[15:0];
    assign in_req.wdata = s_axis_tdata[47:16];

    srisc_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(s_axis_tvalid), .o_ready(s_axis_tready), .i_req(in_req),
        .o_valid(q_valid), .i_ready(q_ready), .o_req(q_req)
    );

    srisc_back u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(q_valid), .o_ready(q_ready), .i_req(q_req),
        .o_valid(m_axis_tvalid), .i_ready(m_axis_tready), .o_res(res)
    );

    assign m_axis_tdata = {5'd0, res.count, res.dropped, res.bad, res.halted,
                           res.pc, res.rdata};
endmodule

// ----- rtl/srisc_checker.sv -----
// Port-level checks for the small RISC step block.
`timescale 1ns / 1ps
module srisc_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [87:0] m_axis_tdata
);
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
        else $error("output word changed while stalled");
    a_pad: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tdata[87:83] == 5'd0)
        else $error("pad bits set");
    a_flags: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tdata[49] |-> m_axis_tdata[50] == 1'b0)
        else $error("bad opcode with drop flag");
    a_halt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tdata[48] |-> m_axis_tdata[49] == 1'b0)
        else $error("bad opcode on halted word");
endmodule

bind small_risc_instruction_step_top srisc_checker u_chk (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready), .m_axis_tdata(m_axis_tdata)
);
